@@ rtl/core/char_lcd_nibble_write_sequencer_assert.svh @@
// Assertion macros shared by the sequencer RTL.
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CLNWS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sequencer check failed (same cycle)");

// Next-cycle implication, disabled during reset.
`define CLNWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sequencer check failed (next cycle)");

`endif

@@ rtl/core/clnws_pkg.sv @@
`timescale 1ns / 1ps
package clnws_pkg;

    // Request kinds
    typedef enum logic [2:0] {
        KIND_POWER = 3'd0,
        KIND_INSTR = 3'd1,
        KIND_DATA  = 3'd2,
        KIND_CLEAR = 3'd3,
        KIND_HOME  = 3'd4
    } t_kind;

    localparam int STEP_W = 5;

    // Set-up register indexes
    localparam logic [1:0] REG_FUNCTION_SET  = 2'd0;
    localparam logic [1:0] REG_SHIFT         = 2'd1;
    localparam logic [1:0] REG_DISPLAY_CTRL  = 2'd2;
    localparam logic [1:0] REG_ENTRY_MODE    = 2'd3;

    // Set-up register reset values
    localparam logic [7:0] RST_FUNCTION_SET  = 8'h28;
    localparam logic [7:0] RST_SHIFT         = 8'h10;
    localparam logic [7:0] RST_DISPLAY_CTRL  = 8'h0F;
    localparam logic [7:0] RST_ENTRY_MODE    = 8'h06;

    // Hold times in microseconds
    localparam logic [15:0] HOLD_POWER_ON = 16'd40000;
    localparam logic [15:0] HOLD_WAKE     = 16'd5000;
    localparam logic [15:0] HOLD_GAP      = 16'd160;
    localparam logic [15:0] HOLD_PULSE    = 16'd10;
    localparam logic [15:0] HOLD_DATA     = 16'd1000;
    localparam logic [15:0] HOLD_LEAD     = 16'd10;
    localparam logic [15:0] HOLD_NONE     = 16'd0;

    // Fixed nibbles and bytes
    localparam logic [3:0] NIB_ZERO   = 4'h0;
    localparam logic [3:0] NIB_WAKE   = 4'h3;
    localparam logic [3:0] NIB_4BIT   = 4'h2;
    localparam logic [7:0] BYTE_CLEAR = 8'h01;
    localparam logic [7:0] BYTE_HOME  = 8'h02;

    // Step offsets inside the power-up sequence
    localparam logic [STEP_W-1:0] PWR_WAKE_FIRST = 5'd2;
    localparam logic [STEP_W-1:0] PWR_WAKE_LAST  = 5'd7;
    localparam logic [STEP_W-1:0] PWR_4BIT_LAST  = 5'd9;
    localparam logic [STEP_W-1:0] PWR_BYTE_FIRST = 5'd10;

    // Controller to datapath command
    typedef struct packed {
        logic              load;
        logic              emit;
        logic              last;
        t_kind             kind;
        logic [STEP_W-1:0] step;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
    } t_dp_sts;

    // Index of the final result of each request kind
    function automatic logic [STEP_W-1:0] last_step(input t_kind kind);
        logic [STEP_W-1:0] r;
        unique case (kind)
            KIND_POWER: r = 5'd25;
            KIND_INSTR: r = 5'd3;
            default:    r = 5'd4;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/clnws_req_if.sv @@
`timescale 1ns / 1ps
interface clnws_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] byte_value;

    modport source (output valid, output kind, output byte_value, input ready);
    modport sink   (input valid, input kind, input byte_value, output ready);
endinterface

@@ rtl/core/clnws_pin_if.sv @@
`timescale 1ns / 1ps
interface clnws_pin_if;
    logic        valid;
    logic        ready;
    logic [3:0]  data_nibble;
    logic        reg_select;
    logic        read_write;
    logic        enable_line;
    logic [15:0] hold_us;
    logic        last;

    modport source (output valid, output data_nibble, output reg_select, output read_write,
                    output enable_line, output hold_us, output last, input ready);
    modport sink   (input valid, input data_nibble, input reg_select, input read_write,
                    input enable_line, input hold_us, input last, output ready);
endinterface

@@ rtl/core/clnws_ctrl.sv @@
`timescale 1ns / 1ps
module clnws_ctrl
    import clnws_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    output logic       o_req_ready,
    input  logic [2:0] i_kind,
    output t_dp_cmd    o_cmd,
    input  t_dp_sts    i_sts
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state            r_state;
    t_kind             r_kind;
    logic [STEP_W-1:0] r_step;
    logic              w_accept;
    logic              w_kind_ok;
    logic              w_emit;
    logic              w_last;

    assign o_req_ready = (r_state == S_IDLE);
    assign w_accept    = i_req_valid && o_req_ready;
    assign w_kind_ok   = (i_kind <= 3'(KIND_HOME));
    assign w_emit      = (r_state == S_RUN) && i_sts.out_free;
    assign w_last      = (r_step == last_step(r_kind));

    // Drive the datapath command
    assign o_cmd.load = w_accept;
    assign o_cmd.emit = w_emit;
    assign o_cmd.last = w_last;
    assign o_cmd.kind = r_kind;
    assign o_cmd.step = r_step;

    // Sequence state: take a request, then walk its results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= KIND_POWER;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && w_kind_ok) begin
                        r_kind  <= t_kind'(i_kind);
                        r_step  <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (w_emit) begin
                        if (w_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_step <= r_step + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/core/clnws_dp.sv @@
`timescale 1ns / 1ps
module clnws_dp
    import clnws_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    input  logic [7:0]  i_byte_value,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    clnws_pin_if.source o_pin
);

    logic [7:0]  r_function_set;
    logic [7:0]  r_shift;
    logic [7:0]  r_display_ctrl;
    logic [7:0]  r_entry_mode;
    logic [7:0]  r_byte;
    logic [3:0]  r_held_nibble;
    logic        r_held_select;
    logic        r_out_valid;
    logic [3:0]  r_out_nibble;
    logic        r_out_select;
    logic        r_out_enable;
    logic [15:0] r_out_hold;
    logic        r_out_last;

    logic [3:0]  n_nibble;
    logic        n_select;
    logic        n_enable;
    logic [15:0] n_hold;
    logic        w_out_free;

    assign w_out_free     = !r_out_valid || o_pin.ready;
    assign o_sts.out_free = w_out_free;

    // Set-up registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_function_set <= RST_FUNCTION_SET;
            r_shift        <= RST_SHIFT;
            r_display_ctrl <= RST_DISPLAY_CTRL;
            r_entry_mode   <= RST_ENTRY_MODE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FUNCTION_SET: r_function_set <= i_cfg_data;
                REG_SHIFT:        r_shift        <= i_cfg_data;
                REG_DISPLAY_CTRL: r_display_ctrl <= i_cfg_data;
                REG_ENTRY_MODE:   r_entry_mode   <= i_cfg_data;
                default:          r_entry_mode   <= r_entry_mode;
            endcase
        end
    end

    // Capture the request byte
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= i_byte_value;
        end
    end

    // Build the pin state for the current step
    always_comb begin
        logic [STEP_W-1:0] s_m1;
        logic [STEP_W-1:0] s_m2;
        logic [STEP_W-1:0] s_m10;
        logic [1:0]        q;
        logic [7:0]        b;
        logic              use_byte;
        logic              q_en;

        s_m1     = i_cmd.step - 5'd1;
        s_m2     = i_cmd.step - PWR_WAKE_FIRST;
        s_m10    = i_cmd.step - PWR_BYTE_FIRST;
        q        = i_cmd.step[1:0];
        b        = r_byte;
        use_byte = 1'b1;
        n_nibble = r_held_nibble;
        n_select = r_held_select;
        n_enable = 1'b0;
        n_hold   = HOLD_NONE;

        case (i_cmd.kind) inside
            KIND_POWER: begin
                n_select = 1'b0;
                use_byte = 1'b0;
                if (i_cmd.step == 5'd0) begin
                    n_nibble = NIB_ZERO;
                    n_hold   = HOLD_POWER_ON;
                end else if (i_cmd.step < PWR_WAKE_FIRST) begin
                    n_nibble = NIB_WAKE;
                    n_hold   = HOLD_WAKE;
                end else if (i_cmd.step <= PWR_WAKE_LAST) begin
                    n_nibble = NIB_WAKE;
                    n_enable = !s_m2[0];
                    n_hold   = s_m2[0] ? HOLD_GAP : HOLD_PULSE;
                end else if (i_cmd.step <= PWR_4BIT_LAST) begin
                    n_nibble = NIB_4BIT;
                    n_enable = !s_m2[0];
                    n_hold   = s_m2[0] ? HOLD_NONE : HOLD_PULSE;
                end else begin
                    use_byte = 1'b1;
                    q        = s_m10[1:0];
                    case (s_m10[3:2])
                        REG_FUNCTION_SET: b = r_function_set;
                        REG_SHIFT:        b = r_shift;
                        REG_DISPLAY_CTRL: b = r_display_ctrl;
                        default:          b = r_entry_mode;
                    endcase
                end
            end
            KIND_INSTR: begin
                n_select = 1'b0;
            end
            KIND_DATA: begin
                if (i_cmd.step == 5'd0) begin
                    use_byte = 1'b0;
                    n_hold   = HOLD_DATA;
                end else begin
                    n_select = 1'b1;
                    q        = s_m1[1:0];
                end
            end
            KIND_CLEAR, KIND_HOME: begin
                b = (i_cmd.kind == KIND_CLEAR) ? BYTE_CLEAR : BYTE_HOME;
                if (i_cmd.step == 5'd0) begin
                    use_byte = 1'b0;
                    n_hold   = HOLD_LEAD;
                end else begin
                    n_select = 1'b0;
                    q        = s_m1[1:0];
                end
            end
            default: begin
                use_byte = 1'b0;
            end
        endcase

        // High nibble then low nibble, each as enable high then low
        q_en = !q[0];
        if (use_byte) begin
            n_nibble = q[1] ? b[3:0] : b[7:4];
            n_enable = q_en;
            n_hold   = q_en ? HOLD_PULSE : HOLD_NONE;
        end
    end

    // Output register and the pins last driven
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_held_nibble <= '0;
            r_held_select <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid   <= 1'b1;
            r_held_nibble <= n_nibble;
            r_held_select <= n_select;
        end else if (o_pin.ready) begin
            r_out_valid   <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_nibble <= n_nibble;
            r_out_select <= n_select;
            r_out_enable <= n_enable;
            r_out_hold   <= n_hold;
            r_out_last   <= i_cmd.last;
        end
    end

    assign o_pin.valid       = r_out_valid;
    assign o_pin.data_nibble = r_out_nibble;
    assign o_pin.reg_select  = r_out_select;
    assign o_pin.read_write  = 1'b0;
    assign o_pin.enable_line = r_out_enable;
    assign o_pin.hold_us     = r_out_hold;
    assign o_pin.last        = r_out_last;

endmodule

@@ rtl/core/char_lcd_nibble_write_sequencer.sv @@
`timescale 1ns / 1ps
// 4-bit character LCD write sequencer. Each request (power-up, instruction,
// data byte, clear, home) becomes a list of timed pin states: data nibble,
// register select, read/write, enable level and a hold time in microseconds,
// with last set on the final state. A byte goes out high nibble first, each
// nibble as an enable-high then an enable-low state. The input accepts a
// request, then the result stage emits one state per clock while the sink
// takes them. The input stays closed until a request's last state is out;
// sink stalls keep it closed longer. A kind above 4 is taken and dropped. A
// new request can be taken once its predecessor's last state has entered the
// output register. The user must write the four set-up bytes used by power-up
// through the config port only while the block is idle; the block itself
// does not enforce this.
`include "char_lcd_nibble_write_sequencer_assert.svh"
module char_lcd_nibble_write_sequencer
    import clnws_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    clnws_req_if.sink   i_req,
    clnws_pin_if.source o_pin,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    clnws_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_kind      (i_req.kind),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    clnws_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_byte_value (i_req.byte_value),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_pin        (o_pin)
    );

    // A known request keeps the input closed until its last state is out
    `CLNWS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_req.valid && i_req.ready && (i_req.kind <= 3'(KIND_HOME)), !i_req.ready)
    // Never overwrite a result the sink has not taken
    `CLNWS_ASSERT_NOW(a_emit_into_free, i_clk, i_rst_n, w_cmd.emit, w_sts.out_free)
    // After the last state is issued the input opens again
    `CLNWS_ASSERT_NEXT(a_ready_after_last, i_clk, i_rst_n, w_cmd.emit && w_cmd.last, i_req.ready && o_pin.valid && o_pin.last)

endmodule
